### hdl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, codes and constants of the LED cue sequencer with crossfade.
// ----------------------------------------------------------------------------
package lcs_pkg;

	// default sizes of the show and cue stores
	localparam int SHOW_COUNT_DEF    = 8;
	localparam int CUES_PER_SHOW_DEF = 16;

	// command codes
	localparam logic [3:0] CMD_TICK   = 4'd0;
	localparam logic [3:0] CMD_START  = 4'd1;
	localparam logic [3:0] CMD_STOP   = 4'd2;
	localparam logic [3:0] CMD_PAUSE  = 4'd3;
	localparam logic [3:0] CMD_RESUME = 4'd4;
	localparam logic [3:0] CMD_TRIG   = 4'd5;
	localparam logic [3:0] CMD_WRCUE  = 4'd6;
	localparam logic [3:0] CMD_WRHDR  = 4'd7;
	localparam logic [3:0] CMD_MASTER = 4'd8;

	// stop modes on the input side
	localparam logic [1:0] MODE_RESTORE = 2'd0;
	localparam logic [1:0] MODE_OFF     = 2'd1;
	localparam logic [1:0] MODE_LEAVE   = 2'd2;

	// stop actions on the output side
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_RESTORE = 2'd1;
	localparam logic [1:0] ACT_BLANK   = 2'd2;
	localparam logic [1:0] ACT_LEAVE   = 2'd3;

	// fade phases
	localparam logic [1:0] FADE_NONE = 2'd0;
	localparam logic [1:0] FADE_OUT  = 2'd1;
	localparam logic [1:0] FADE_IN   = 2'd2;

	// cue duration that waits for the effect-done flag
	localparam logic [15:0] DUR_EFFECT = 16'hFFFF;
	// brightness scaling: (master * level + 127) / 255
	localparam logic [7:0] LEVEL_FULL  = 8'd255;
	localparam logic [7:0] ROUND_HALF  = 8'd127;
	localparam logic [25:0] ELAPSED_MAX = 26'h3FFFFFF;
	localparam logic [15:0] FADE_EL_MAX = 16'hFFFF;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [3:0]  show_number;
		logic [4:0]  cue_number;
		logic        effect_done;
		logic [7:0]  master_level;
		logic [15:0] duration_s;
		logic [15:0] fade_time_ms;
		logic [7:0]  cue_level;
		logic [1:0]  show_flags;
		logic [3:0]  next_show;
		logic [1:0]  stop_mode;
	} item_t;

	typedef struct packed {
		logic [7:0] brightness_out;
		logic       running;
		logic       frozen;
		logic [3:0] active_show;
		logic [3:0] active_cue;
		logic       cue_applied;
		logic [1:0] stop_action;
		logic       accepted;
	} result_t;

	// show header entry
	typedef struct packed {
		logic [4:0] count;
		logic [3:0] next;
		logic       loop;
		logic       en;
	} hdr_t;

	// cue entry
	typedef struct packed {
		logic [15:0] dur;
		logic [15:0] fade;
		logic [7:0]  lvl;
	} cue_t;

	// request to the serial multiply-divide unit: (a * b + addend) / divisor
	typedef struct packed {
		logic [7:0]  a;
		logic [15:0] b;
		logic [7:0]  addend;
		logic [15:0] divisor;
	} mdu_req_t;

endpackage

### hdl/lcs_serial_muldiv.sv
// ----------------------------------------------------------------------------
// lcs_serial_muldiv
// Bit-serial (a * b + addend) / divisor: 8 shift-add steps, then 24 restoring
// divide steps. Returns the low 8 quotient bits with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module lcs_serial_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lcs_pkg::mdu_req_t req,
	output logic              done,
	output logic [7:0]        quo
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	logic [1:0]  ph_q;
	logic [4:0]  cnt_q;
	logic [7:0]  a_q;
	logic [23:0] bsh_q;
	logic [23:0] acc_q;
	logic [15:0] d_q;
	logic [15:0] rem_q;
	logic        done_q;

	logic [16:0] trial;
	logic        fits;

	// one restoring divide step
	assign trial = {rem_q, acc_q[23]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			cnt_q  <= '0;
			a_q    <= '0;
			bsh_q  <= '0;
			acc_q  <= '0;
			d_q    <= '0;
			rem_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						a_q   <= req.a;
						bsh_q <= {8'd0, req.b};
						acc_q <= {16'd0, req.addend};
						d_q   <= req.divisor;
						cnt_q <= '0;
						ph_q  <= PH_MUL;
					end
				end
				PH_MUL: begin
					if (a_q[0]) begin
						acc_q <= acc_q + bsh_q;
					end
					a_q   <= a_q >> 1;
					bsh_q <= bsh_q << 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd7) begin
						cnt_q <= '0;
						rem_q <= '0;
						ph_q  <= PH_DIV;
					end
				end
				PH_DIV: begin
					rem_q <= fits ? 16'(trial - {1'b0, d_q}) : trial[15:0];
					acc_q <= {acc_q[22:0], fits};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) begin
						done_q <= 1'b1;
						ph_q   <= PH_IDLE;
					end
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quo  = acc_q[7:0];

endmodule

### hdl/led_cue_sequencer_with_crossfade_core.sv
// Words that need no scaling pass through decode and, where needed, a store read;
// a word that applies a cue or steps a fade ramp also waits for the serial multiply-divide.
// Both wait while a stalled result word blocks the output register.
// Throughput: one word at a time; the next word is taken once the result is stored.
// Reset: asynchronous, clears show state and header valid bits; the cue store
// holds undefined data until written and needs no clearing pass.
// ----------------------------------------------------------------------------
// led_cue_sequencer_with_crossfade_core
// Cue sequencer with crossfade: command decode, show/cue stores and a
// sequencer that uses one bit-serial multiply-divide unit for brightness.
// ----------------------------------------------------------------------------
module led_cue_sequencer_with_crossfade_core #(
	parameter int SHOW_COUNT    = lcs_pkg::SHOW_COUNT_DEF,
	parameter int CUES_PER_SHOW = lcs_pkg::CUES_PER_SHOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  lcs_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output lcs_pkg::result_t result
);

	localparam int DEPTH  = SHOW_COUNT * CUES_PER_SHOW;
	localparam int HIDX_W = SHOW_COUNT > 1 ? $clog2(SHOW_COUNT) : 1;
	localparam int SLOT_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_WAIT  = 4'd2;
	localparam logic [3:0] S_START = 4'd3;
	localparam logic [3:0] S_TICK  = 4'd4;
	localparam logic [3:0] S_TICK2 = 4'd5;
	localparam logic [3:0] S_ADV   = 4'd6;
	localparam logic [3:0] S_TRIG  = 4'd7;
	localparam logic [3:0] S_APPLY = 4'd8;
	localparam logic [3:0] S_MDU   = 4'd9;
	localparam logic [3:0] S_STOP  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [3:0] s, input logic [3:0] c);
		slot_of = SLOT_W'((32'(s) - 32'd1) * CUES_PER_SHOW + 32'(c));
	endfunction

	function automatic logic [HIDX_W-1:0] hidx_of(input logic [3:0] s);
		hidx_of = HIDX_W'(32'(s) - 32'd1);
	endfunction

	// sequencer state
	logic [3:0]  state_q, ret_q;
	lcs_pkg::item_t it_q;
	logic [3:0]  show_q, cue_q, num_q;
	logic [25:0] cue_el_q, thr_q;
	logic [15:0] fade_el_q, fade_len_q;
	logic [1:0]  phase_q, stop_mode_q;
	logic [7:0]  from_q, cue_lvl_q, master_q, level_q;
	logic        paused_q, chain_q, fade_ctx_q;
	logic        applied_q, accept_q;
	logic [1:0]  stop_code_q;

	// stores
	lcs_pkg::hdr_t hdr_mem [SHOW_COUNT];
	logic [SHOW_COUNT-1:0] hdr_vld_q;
	lcs_pkg::cue_t cue_mem [DEPTH];
	logic [HIDX_W-1:0] hdr_idx_q;
	logic [SLOT_W-1:0] cue_idx_q;
	lcs_pkg::hdr_t hdr_rd_q;
	logic          hdr_vld_rd_q;
	lcs_pkg::cue_t cue_rd_q;
	lcs_pkg::hdr_t hdr_eff;

	// multiply-divide unit
	logic              mdu_go_q, mdu_done;
	lcs_pkg::mdu_req_t mdu_req_q;
	logic [7:0]        mdu_quo;

	// output register
	lcs_pkg::result_t out_q;
	logic             out_valid_q;

	logic        cue_we, hdr_we;
	logic [15:0] half_raw, half;
	logic        dur_go;
	logic [4:0]  cnt_sat;
	logic [25:0] dur_ext;

	assign hdr_eff  = hdr_vld_rd_q ? hdr_rd_q : '0;
	assign half_raw = fade_len_q >> 1;
	assign half     = (half_raw == 16'd0) ? 16'd1 : half_raw;
	assign dur_ext  = {10'd0, cue_rd_q.dur};
	assign dur_go   = (cue_rd_q.dur == lcs_pkg::DUR_EFFECT) ? it_q.effect_done :
		(cue_rd_q.dur != 16'd0) && (cue_el_q >= thr_q);
	assign cnt_sat  = (32'(it_q.cue_number) > CUES_PER_SHOW) ?
		5'(CUES_PER_SHOW) : it_q.cue_number;

	// write enables of the stores
	assign cue_we = (state_q == S_DEC) && (it_q.cmd == lcs_pkg::CMD_WRCUE) &&
		(it_q.show_number != 4'd0) && (32'(it_q.show_number) <= SHOW_COUNT) &&
		(it_q.cue_number != 5'd0) && (32'(it_q.cue_number) <= CUES_PER_SHOW);
	assign hdr_we = (state_q == S_DEC) && (it_q.cmd == lcs_pkg::CMD_WRHDR) &&
		(it_q.show_number != 4'd0) && (32'(it_q.show_number) <= SHOW_COUNT);

	// cue store: one write, one registered read
	always_ff @(posedge clk) begin
		if (cue_we) begin
			cue_mem[slot_of(it_q.show_number, 4'(it_q.cue_number - 5'd1))] <=
				'{dur: it_q.duration_s, fade: it_q.fade_time_ms, lvl: it_q.cue_level};
		end
		cue_rd_q <= cue_mem[cue_idx_q];
	end

	// header store with valid bits; an unwritten header reads as zero
	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[hidx_of(it_q.show_number)] <=
				'{count: cnt_sat, next: it_q.next_show, loop: it_q.show_flags[1],
				en: it_q.show_flags[0]};
		end
		hdr_rd_q <= hdr_mem[hdr_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_vld_q    <= '0;
			hdr_vld_rd_q <= 1'b0;
		end else begin
			if (hdr_we) begin
				hdr_vld_q[hidx_of(it_q.show_number)] <= 1'b1;
			end
			hdr_vld_rd_q <= hdr_vld_q[hdr_idx_q];
		end
	end

	lcs_serial_muldiv u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mdu_go_q),
		.req    (mdu_req_q),
		.done   (mdu_done),
		.quo    (mdu_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			it_q        <= '0;
			show_q      <= '0;
			cue_q       <= '0;
			num_q       <= '0;
			cue_el_q    <= '0;
			thr_q       <= '0;
			fade_el_q   <= '0;
			fade_len_q  <= '0;
			phase_q     <= lcs_pkg::FADE_NONE;
			stop_mode_q <= lcs_pkg::MODE_RESTORE;
			from_q      <= lcs_pkg::LEVEL_FULL;
			cue_lvl_q   <= lcs_pkg::LEVEL_FULL;
			master_q    <= lcs_pkg::LEVEL_FULL;
			level_q     <= lcs_pkg::LEVEL_FULL;
			paused_q    <= 1'b0;
			chain_q     <= 1'b0;
			fade_ctx_q  <= 1'b0;
			applied_q   <= 1'b0;
			accept_q    <= 1'b0;
			stop_code_q <= lcs_pkg::ACT_NONE;
			hdr_idx_q   <= '0;
			cue_idx_q   <= '0;
			mdu_go_q    <= 1'b0;
			mdu_req_q   <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mdu_go_q <= 1'b0;
			if (out_valid_q && !result_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						it_q        <= item;
						applied_q   <= 1'b0;
						accept_q    <= 1'b0;
						stop_code_q <= lcs_pkg::ACT_NONE;
						fade_ctx_q  <= 1'b0;
						chain_q     <= 1'b0;
						state_q     <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_DONE;
					case (it_q.cmd)
						lcs_pkg::CMD_TICK: begin
							if (show_q != 4'd0 && !paused_q) begin
								hdr_idx_q <= hidx_of(show_q);
								cue_idx_q <= slot_of(show_q, cue_q);
								ret_q     <= S_TICK;
								state_q   <= S_WAIT;
							end
						end
						lcs_pkg::CMD_START: begin
							if (it_q.show_number == 4'd0) begin
								stop_mode_q <= lcs_pkg::MODE_RESTORE;
								state_q     <= S_STOP;
							end else if (32'(it_q.show_number) <= SHOW_COUNT) begin
								num_q     <= it_q.show_number;
								hdr_idx_q <= hidx_of(it_q.show_number);
								ret_q     <= S_START;
								state_q   <= S_WAIT;
							end
						end
						lcs_pkg::CMD_STOP: begin
							stop_mode_q <= it_q.stop_mode;
							state_q     <= S_STOP;
						end
						lcs_pkg::CMD_PAUSE: begin
							if (show_q != 4'd0) begin
								paused_q <= 1'b1;
							end
						end
						lcs_pkg::CMD_RESUME: begin
							if (show_q != 4'd0 && paused_q) begin
								paused_q <= 1'b0;
								if (phase_q == lcs_pkg::FADE_NONE) begin
									mdu_req_q <= '{a: master_q, b: {8'd0, cue_lvl_q},
										addend: lcs_pkg::ROUND_HALF,
										divisor: {8'd0, lcs_pkg::LEVEL_FULL}};
									mdu_go_q  <= 1'b1;
									state_q   <= S_MDU;
								end
							end
						end
						lcs_pkg::CMD_TRIG: begin
							if (show_q != 4'd0) begin
								hdr_idx_q <= hidx_of(show_q);
								ret_q     <= S_TRIG;
								state_q   <= S_WAIT;
							end
						end
						lcs_pkg::CMD_MASTER: begin
							master_q <= it_q.master_level;
							if (show_q != 4'd0 && phase_q == lcs_pkg::FADE_NONE) begin
								mdu_req_q <= '{a: it_q.master_level, b: {8'd0, cue_lvl_q},
									addend: lcs_pkg::ROUND_HALF,
									divisor: {8'd0, lcs_pkg::LEVEL_FULL}};
								mdu_go_q  <= 1'b1;
								state_q   <= S_MDU;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				// store read latency
				S_WAIT: state_q <= ret_q;
				S_START: begin
					if (hdr_eff.en) begin
						show_q     <= num_q;
						cue_q      <= '0;
						cue_el_q   <= '0;
						phase_q    <= lcs_pkg::FADE_NONE;
						fade_el_q  <= '0;
						fade_len_q <= '0;
						from_q     <= lcs_pkg::LEVEL_FULL;
						cue_lvl_q  <= lcs_pkg::LEVEL_FULL;
						paused_q   <= 1'b0;
						accept_q   <= !chain_q;
						cue_idx_q  <= slot_of(num_q, 4'd0);
						ret_q      <= S_APPLY;
						state_q    <= S_WAIT;
					end else if (chain_q) begin
						stop_mode_q <= lcs_pkg::MODE_RESTORE;
						state_q     <= S_STOP;
					end else begin
						state_q <= S_DONE;
					end
				end
				// time counters, then the cue range check
				S_TICK: begin
					if (cue_el_q != lcs_pkg::ELAPSED_MAX) begin
						cue_el_q <= cue_el_q + 26'd1;
					end
					if (phase_q != lcs_pkg::FADE_NONE && fade_el_q != lcs_pkg::FADE_EL_MAX) begin
						fade_el_q <= fade_el_q + 16'd1;
					end
					// dur * 1000 = dur * 1024 - dur * 16 - dur * 8
					thr_q <= (dur_ext << 10) - (dur_ext << 4) - (dur_ext << 3);
					if ({1'b0, cue_q} >= hdr_eff.count) begin
						cue_q   <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_TICK2;
					end
				end
				S_TICK2: begin
					state_q <= S_DONE;
					if (phase_q == lcs_pkg::FADE_OUT) begin
						if (fade_el_q < half) begin
							mdu_req_q <= '{a: from_q, b: half - fade_el_q, addend: 8'd0,
								divisor: half};
							mdu_go_q  <= 1'b1;
							state_q   <= S_MDU;
						end else begin
							fade_ctx_q <= 1'b1;
							state_q    <= S_ADV;
						end
					end else if (phase_q != lcs_pkg::FADE_NONE) begin
						if (fade_el_q < half) begin
							mdu_req_q <= '{a: from_q, b: fade_el_q, addend: 8'd0,
								divisor: half};
							mdu_go_q  <= 1'b1;
							state_q   <= S_MDU;
						end else begin
							level_q <= from_q;
							phase_q <= lcs_pkg::FADE_NONE;
						end
					end else if (dur_go) begin
						if (cue_rd_q.fade != 16'd0) begin
							phase_q    <= lcs_pkg::FADE_OUT;
							fade_el_q  <= '0;
							fade_len_q <= cue_rd_q.fade;
							from_q     <= level_q;
						end else begin
							state_q <= S_ADV;
						end
					end
				end
				// next cue, loop, chain or stop
				S_ADV: begin
					if ({1'b0, cue_q} + 5'd1 < hdr_eff.count) begin
						cue_q     <= cue_q + 4'd1;
						cue_idx_q <= slot_of(show_q, cue_q + 4'd1);
						ret_q     <= S_APPLY;
						state_q   <= S_WAIT;
					end else if (hdr_eff.loop) begin
						cue_q     <= '0;
						cue_idx_q <= slot_of(show_q, 4'd0);
						ret_q     <= S_APPLY;
						state_q   <= S_WAIT;
					end else if (hdr_eff.next != 4'd0 && 32'(hdr_eff.next) <= SHOW_COUNT) begin
						num_q     <= hdr_eff.next;
						chain_q   <= 1'b1;
						hdr_idx_q <= hidx_of(hdr_eff.next);
						ret_q     <= S_START;
						state_q   <= S_WAIT;
					end else begin
						stop_mode_q <= lcs_pkg::MODE_RESTORE;
						state_q     <= S_STOP;
					end
				end
				S_TRIG: begin
					if (it_q.cue_number != 5'd0 && hdr_eff.en &&
						it_q.cue_number <= hdr_eff.count) begin
						cue_q     <= 4'(it_q.cue_number - 5'd1);
						phase_q   <= lcs_pkg::FADE_NONE;
						fade_el_q <= '0;
						accept_q  <= 1'b1;
						cue_idx_q <= slot_of(show_q, 4'(it_q.cue_number - 5'd1));
						ret_q     <= S_APPLY;
						state_q   <= S_WAIT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_APPLY: begin
					cue_lvl_q <= cue_rd_q.lvl;
					cue_el_q  <= '0;
					applied_q <= 1'b1;
					mdu_req_q <= '{a: master_q, b: {8'd0, cue_rd_q.lvl},
						addend: lcs_pkg::ROUND_HALF,
						divisor: {8'd0, lcs_pkg::LEVEL_FULL}};
					mdu_go_q  <= 1'b1;
					state_q   <= S_MDU;
				end
				S_MDU: begin
					if (mdu_done) begin
						if (fade_ctx_q) begin
							// cue switched mid-crossfade: ramp up from zero
							phase_q   <= lcs_pkg::FADE_IN;
							fade_el_q <= '0;
							from_q    <= mdu_quo;
							level_q   <= 8'd0;
						end else begin
							level_q <= mdu_quo;
						end
						state_q <= S_DONE;
					end
				end
				S_STOP: begin
					if (show_q != 4'd0) begin
						if (phase_q != lcs_pkg::FADE_NONE) begin
							level_q <= from_q;
						end
						show_q   <= '0;
						cue_q    <= '0;
						phase_q  <= lcs_pkg::FADE_NONE;
						paused_q <= 1'b0;
						case (stop_mode_q)
							lcs_pkg::MODE_LEAVE: stop_code_q <= lcs_pkg::ACT_LEAVE;
							lcs_pkg::MODE_OFF:   stop_code_q <= lcs_pkg::ACT_BLANK;
							default:             stop_code_q <= lcs_pkg::ACT_RESTORE;
						endcase
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !result_stall) begin
						out_q <= '{brightness_out: level_q, running: show_q != 4'd0,
							frozen: paused_q, active_show: show_q, active_cue: cue_q,
							cue_applied: applied_q, stop_action: stop_code_q,
							accepted: accept_q};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_stall   = state_q != S_IDLE;
	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTH
	a_mdu_go: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_go_q |-> state_q == S_MDU)
		else $error("multiply-divide started outside its wait state");
	a_mdu_done: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_done |-> state_q == S_MDU)
		else $error("multiply-divide result with no consumer");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_DONE)
		else $error("result word loaded outside the done state");
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frozen |-> result.running && result.active_show != 4'd0)
		else $error("paused with no active show");
`endif

endmodule
